>>> hdl/als_pkg.sv
`default_nettype none
package als_pkg;

  // Coordinate bits taken from each end point field.
  localparam int COORD_BITS = 12;
  // Width of the end point fields on the input channel.
  localparam int IN_W       = 12;
  // Width of the signed pixel coordinates on the result channel.
  localparam int OUT_W      = 14;
  localparam int COVER_W    = 8;
  // Slope is 1.16 fixed point and never exceeds 1.0, so 17 bits hold it.
  localparam int SLOPE_W    = 17;
  localparam int ERR_W      = 20;
  localparam int REM_W      = COORD_BITS + 1;
  localparam int CNT_W      = $clog2(SLOPE_W);

  localparam logic [ERR_W-1:0]   ONE_FIX  = 20'h10000;
  localparam logic [ERR_W-1:0]   HALF_FIX = 20'h08000;
  localparam logic [COVER_W-1:0] ALPHA_HALF = 8'h7F;
  localparam logic [COVER_W-1:0] COVER_FULL = 8'hFF;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

endpackage
`default_nettype wire

>>> hdl/als_ifs.sv
`default_nettype none
// Input channel: one load or step item per handshake.
interface als_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [als_pkg::IN_W-1:0]   start_x;
  logic [als_pkg::IN_W-1:0]   start_y;
  logic [als_pkg::IN_W-1:0]   end_x;
  logic [als_pkg::IN_W-1:0]   end_y;

  modport source (output valid, op, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, op, start_x, start_y, end_x, end_y, output ready);
endinterface

// Result channel: one pixel pair per handshake.
interface als_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [als_pkg::OUT_W-1:0]   main_x;
  logic signed [als_pkg::OUT_W-1:0]   main_y;
  logic        [als_pkg::COVER_W-1:0] main_cover;
  logic signed [als_pkg::OUT_W-1:0]   side_x;
  logic signed [als_pkg::OUT_W-1:0]   side_y;
  logic        [als_pkg::COVER_W-1:0] side_cover;
  logic                               side_valid;
  logic                               last;

  modport source (output valid, main_x, main_y, main_cover, side_x, side_y, side_cover,
                  side_valid, last, input ready);
  modport sink   (input valid, main_x, main_y, main_cover, side_x, side_y, side_cover,
                  side_valid, last, output ready);
endinterface
`default_nettype wire

>>> hdl/antialiased_line_stepper.sv
`default_nettype none
// Antialiased line stepper. A load item (op = 0) latches a line from its start to
// its end point and produces no result; a step item (op = 1) produces one pixel
// pair: the pixel on the line with coverage 255 xor alpha and its neighbor one
// minor-axis unit over with coverage alpha, the final pair flagged by last.
// Steps with no line loaded are dropped without a result. A step item is accepted
// whenever the divider is idle and the result register is empty or is being
// emptied in the same cycle, so steps stream at one pixel pair per clock while
// the receiver takes them. A load of an axis-aligned line (or a single point)
// skips the divide and its pairs have no neighbor. Any other load runs a restoring
// divider for the 1.16 slope that shares one compare-and-subtract unit over 17
// iterations, one quotient bit per cycle, with in_line.ready low until done. A
// load discards any line still in progress. Reset is synchronous and active low.
module antialiased_line_stepper (
  input  wire logic   clk,
  input  wire logic   rst_n,
  als_in_if.sink      in_line,
  als_out_if.source   out_pix
);

  localparam int CB  = als_pkg::COORD_BITS;
  localparam int OW  = als_pkg::OUT_W;
  localparam int CW  = als_pkg::COVER_W;
  localparam int SW  = als_pkg::SLOPE_W;
  localparam int EW  = als_pkg::ERR_W;
  localparam int RW  = als_pkg::REM_W;
  localparam int NW  = als_pkg::CNT_W;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  // Control state.
  state_t          state_r, state_nxt;
  logic            line_active_r, line_active_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Line state.
  logic [OW-1:0]   cur_x_r, cur_x_nxt;
  logic [OW-1:0]   cur_y_r, cur_y_nxt;
  logic [CB-1:0]   stop_major_r, stop_major_nxt;
  logic            x_neg_r, x_neg_nxt;
  logic            y_neg_r, y_neg_nxt;
  logic            y_major_r, y_major_nxt;
  logic            aligned_r, aligned_nxt;
  logic [SW-1:0]   slope_r, slope_nxt;
  logic [EW-1:0]   err_r, err_nxt;
  logic [CW-1:0]   alpha_r, alpha_nxt;

  // Divider state.
  logic [CB-1:0]   den_r, den_nxt;
  logic [RW-1:0]   rem_r, rem_nxt;
  logic [SW-1:0]   quo_r, quo_nxt;
  logic [NW-1:0]   cnt_r, cnt_nxt;

  // Result register.
  logic [OW-1:0]   main_x_r, main_x_nxt;
  logic [OW-1:0]   main_y_r, main_y_nxt;
  logic [CW-1:0]   main_cover_r, main_cover_nxt;
  logic [OW-1:0]   side_x_r, side_x_nxt;
  logic [OW-1:0]   side_y_r, side_y_nxt;
  logic [CW-1:0]   side_cover_r, side_cover_nxt;
  logic            side_valid_r, side_valid_nxt;
  logic            last_r, last_nxt;

  logic            in_ready;
  logic            in_fire;

  // Load decode.
  logic [CB-1:0]   x1, y1, x2, y2;
  logic [CB:0]     dx, dy;
  logic [CB-1:0]   adx, ady;
  logic            ld_y_major;
  logic [CB-1:0]   ld_maj, ld_mnr;

  // Step datapath.
  logic [OW-1:0]   step_x, step_y;
  logic [OW-1:0]   major_pos;
  logic            fin;
  logic [EW-1:0]   slope_ext;

  // Shared compare-and-subtract unit of the divider.
  logic            div_ge;
  logic [RW-1:0]   div_diff;
  logic [RW-1:0]   div_sel;
  logic [SW-1:0]   div_quo;
  logic [EW-1:0]   div_err;

  assign in_ready       = (state_r == ST_IDLE) && (!out_valid_r || out_pix.ready);
  assign in_fire        = in_line.valid && in_ready;
  assign in_line.ready  = in_ready;

  assign x1 = in_line.start_x[CB-1:0];
  assign y1 = in_line.start_y[CB-1:0];
  assign x2 = in_line.end_x[CB-1:0];
  assign y2 = in_line.end_y[CB-1:0];
  assign dx = {1'b0, x2} - {1'b0, x1};
  assign dy = {1'b0, y2} - {1'b0, y1};
  // The magnitude of a difference of two CB-bit values always fits in CB bits.
  assign adx = dx[CB] ? CB'(-dx) : dx[CB-1:0];
  assign ady = dy[CB] ? CB'(-dy) : dy[CB-1:0];
  assign ld_y_major = adx < ady;
  assign ld_maj     = ld_y_major ? ady : adx;
  assign ld_mnr     = ld_y_major ? adx : ady;

  assign step_x    = x_neg_r ? {OW{1'b1}} : {{(OW-1){1'b0}}, 1'b1};
  assign step_y    = y_neg_r ? {OW{1'b1}} : {{(OW-1){1'b0}}, 1'b1};
  assign major_pos = y_major_r ? cur_y_r : cur_x_r;
  assign fin       = major_pos == {{(OW-CB){1'b0}}, stop_major_r};
  assign slope_ext = {{(EW-SW){1'b0}}, slope_r};

  // The partial remainder is always below the divisor after the subtract, so
  // doubling it never overflows RW bits.
  assign div_ge   = rem_r >= {1'b0, den_r};
  assign div_diff = rem_r - {1'b0, den_r};
  assign div_sel  = div_ge ? div_diff : rem_r;
  assign div_quo  = {quo_r[SW-2:0], div_ge};
  assign div_err  = {{(EW-SW){1'b0}}, div_quo} - als_pkg::HALF_FIX;

  always_comb begin
    state_nxt       = state_r;
    line_active_nxt = line_active_r;
    out_valid_nxt   = out_valid_r && !out_pix.ready;
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    stop_major_nxt  = stop_major_r;
    x_neg_nxt       = x_neg_r;
    y_neg_nxt       = y_neg_r;
    y_major_nxt     = y_major_r;
    aligned_nxt     = aligned_r;
    slope_nxt       = slope_r;
    err_nxt         = err_r;
    alpha_nxt       = alpha_r;
    den_nxt         = den_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    cnt_nxt         = cnt_r;
    main_x_nxt      = main_x_r;
    main_y_nxt      = main_y_r;
    main_cover_nxt  = main_cover_r;
    side_x_nxt      = side_x_r;
    side_y_nxt      = side_y_r;
    side_cover_nxt  = side_cover_r;
    side_valid_nxt  = side_valid_r;
    last_nxt        = last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_line.op == als_pkg::OP_LOAD)) begin
          x_neg_nxt       = dx[CB];
          y_neg_nxt       = dy[CB];
          y_major_nxt     = ld_y_major;
          cur_x_nxt       = {{(OW-CB){1'b0}}, x1};
          cur_y_nxt       = {{(OW-CB){1'b0}}, y1};
          stop_major_nxt  = ld_y_major ? y2 : x2;
          aligned_nxt     = (ld_mnr == '0);
          line_active_nxt = 1'b1;
          slope_nxt       = '0;
          err_nxt         = '0;
          alpha_nxt       = '0;
          den_nxt         = ld_maj;
          rem_nxt         = {1'b0, ld_mnr};
          quo_nxt         = '0;
          cnt_nxt         = '0;
          if (ld_mnr != '0) begin
            state_nxt = ST_DIV;
          end
        end else if (in_fire && line_active_r) begin
          out_valid_nxt  = 1'b1;
          main_x_nxt     = cur_x_r;
          main_y_nxt     = cur_y_r;
          main_cover_nxt = als_pkg::COVER_FULL ^ alpha_r;
          last_nxt       = fin;
          if (aligned_r) begin
            side_x_nxt     = '0;
            side_y_nxt     = '0;
            side_cover_nxt = '0;
            side_valid_nxt = 1'b0;
          end else begin
            side_x_nxt     = y_major_r ? cur_x_r + step_x : cur_x_r;
            side_y_nxt     = y_major_r ? cur_y_r : cur_y_r + step_y;
            side_cover_nxt = alpha_r;
            side_valid_nxt = 1'b1;
          end
          if (fin) begin
            line_active_nxt = 1'b0;
          end else begin
            if (!aligned_r) begin
              if (!err_r[EW-1]) begin
                // Error crossed the half pixel: move one unit along the minor axis.
                alpha_nxt = '0;
                err_nxt   = err_r + slope_ext - als_pkg::ONE_FIX;
                if (y_major_r) begin
                  cur_x_nxt = cur_x_r + step_x;
                end else begin
                  cur_y_nxt = cur_y_r + step_y;
                end
              end else begin
                alpha_nxt = err_r[15:8];
                err_nxt   = err_r + slope_ext;
              end
            end
            if (y_major_r) begin
              cur_y_nxt = (y_major_r ? cur_y_r : cur_y_nxt) + step_y;
            end else begin
              cur_x_nxt = cur_x_r + step_x;
            end
          end
        end
      end
      ST_DIV: begin
        rem_nxt = {div_sel[RW-2:0], 1'b0};
        quo_nxt = div_quo;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == NW'(SW - 1)) begin
          slope_nxt = div_quo;
          err_nxt   = div_err;
          alpha_nxt = div_err[EW-1] ? als_pkg::ALPHA_HALF : '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      line_active_r <= 1'b0;
      out_valid_r   <= 1'b0;
      cnt_r         <= '0;
    end else begin
      state_r       <= state_nxt;
      line_active_r <= line_active_nxt;
      out_valid_r   <= out_valid_nxt;
      cnt_r         <= cnt_nxt;
    end
    cur_x_r      <= cur_x_nxt;
    cur_y_r      <= cur_y_nxt;
    stop_major_r <= stop_major_nxt;
    x_neg_r      <= x_neg_nxt;
    y_neg_r      <= y_neg_nxt;
    y_major_r    <= y_major_nxt;
    aligned_r    <= aligned_nxt;
    slope_r      <= slope_nxt;
    err_r        <= err_nxt;
    alpha_r      <= alpha_nxt;
    den_r        <= den_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    main_x_r     <= main_x_nxt;
    main_y_r     <= main_y_nxt;
    main_cover_r <= main_cover_nxt;
    side_x_r     <= side_x_nxt;
    side_y_r     <= side_y_nxt;
    side_cover_r <= side_cover_nxt;
    side_valid_r <= side_valid_nxt;
    last_r       <= last_nxt;
  end

  assign out_pix.valid      = out_valid_r;
  assign out_pix.main_x     = main_x_r;
  assign out_pix.main_y     = main_y_r;
  assign out_pix.main_cover = main_cover_r;
  assign out_pix.side_x     = side_x_r;
  assign out_pix.side_y     = side_y_r;
  assign out_pix.side_cover = side_cover_r;
  assign out_pix.side_valid = side_valid_r;
  assign out_pix.last       = last_r;

endmodule
`default_nettype wire

>>> hdl/als_chk.sv
`default_nettype none
module als_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [als_pkg::OUT_W-1:0]   out_side_x,
  input wire logic [als_pkg::OUT_W-1:0]   out_side_y,
  input wire logic [als_pkg::COVER_W-1:0] out_main_cover,
  input wire logic [als_pkg::COVER_W-1:0] out_side_cover,
  input wire logic                        out_side_valid
);

  // A pending result is held until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A new result only appears after an item was accepted.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without an accepted item");

  // On an aligned line the neighbor is blank and the main pixel fully covered.
  a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_side_valid |-> out_side_x == '0 && out_side_y == '0 &&
      out_side_cover == '0 && out_main_cover == als_pkg::COVER_FULL)
    else $error("aligned pair carries neighbor data");

  // The two coverages of a pair are complementary.
  a_cover: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_side_valid |-> out_main_cover == ~out_side_cover)
    else $error("pair coverages do not complement");

endmodule

bind antialiased_line_stepper als_chk u_als_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_line.valid),
  .in_ready       (in_line.ready),
  .out_valid      (out_pix.valid),
  .out_ready      (out_pix.ready),
  .out_side_x     (out_pix.side_x),
  .out_side_y     (out_pix.side_y),
  .out_main_cover (out_pix.main_cover),
  .out_side_cover (out_pix.side_cover),
  .out_side_valid (out_pix.side_valid)
);
`default_nettype wire

>>> tb/line_pixel_checker.sv
// Watches both channels of the line stepper, predicts every pixel pair from the
// accepted items and compares the pairs that leave the block, field by field.
module line_pixel_checker (
  input  logic clk,
  input  logic rst_n,
  als_in_if    in_mon,
  als_out_if   out_mon,
  output int   mismatches,
  output int   outstanding,
  output int   pairs_checked,
  output int   lines_finished
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OUT_W   = als_pkg::OUT_W;
  localparam int COVER_W = als_pkg::COVER_W;
  localparam int SLOPE_W = als_pkg::SLOPE_W;
  localparam int ERR_W   = als_pkg::ERR_W;
  localparam int COORD_MASK = (1 << als_pkg::COORD_BITS) - 1;

  typedef struct {
    logic signed [OUT_W-1:0] main_x;
    logic signed [OUT_W-1:0] main_y;
    logic [COVER_W-1:0]      main_cover;
    logic signed [OUT_W-1:0] side_x;
    logic signed [OUT_W-1:0] side_y;
    logic [COVER_W-1:0]      side_cover;
    logic                    side_valid;
    logic                    last;
  } pixel_pair_t;

  // Predicted line state.
  logic signed [OUT_W-1:0] pos_x, pos_y, major_stop;
  logic                    dir_x_neg, dir_y_neg, steep, flat, drawing;
  logic [SLOPE_W-1:0]      slope;
  logic signed [ERR_W-1:0] err_acc;
  logic [COVER_W-1:0]      alpha;

  pixel_pair_t expected_pairs[$];

  task automatic clear_line_state();
    pos_x      = '0;
    pos_y      = '0;
    major_stop = '0;
    dir_x_neg  = 1'b0;
    dir_y_neg  = 1'b0;
    steep      = 1'b0;
    flat       = 1'b0;
    drawing    = 1'b0;
    slope      = '0;
    err_acc    = '0;
    alpha      = '0;
  endtask

  task automatic latch_line(input int x1, input int y1, input int x2, input int y2);
    int          dx, dy, maj, mnr;
    int unsigned num;
    dx = x2 - x1;
    dy = y2 - y1;
    dir_x_neg = (dx < 0);
    dir_y_neg = (dy < 0);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    steep = (dx < dy);
    maj = steep ? dy : dx;
    mnr = steep ? dx : dy;
    pos_x = OUT_W'(x1);
    pos_y = OUT_W'(y1);
    major_stop = OUT_W'(steep ? y2 : x2);
    flat = (mnr == 0);
    if (flat) begin
      slope   = '0;
      err_acc = '0;
      alpha   = '0;
    end else begin
      num     = mnr << 16;
      slope   = SLOPE_W'(num / maj);
      err_acc = ERR_W'(slope) - als_pkg::HALF_FIX;
      alpha   = err_acc[ERR_W-1] ? als_pkg::ALPHA_HALF : '0;
    end
    drawing = 1'b1;
  endtask

  // Works out the pair that a step emits and moves one unit along the major axis.
  task automatic predict_pair(output bit emitted, output pixel_pair_t px);
    int                      sx, sy;
    logic signed [OUT_W-1:0] nx, ny;
    bit                      fin;
    emitted = 1'b0;
    px = '{default: '0};
    if (!drawing) return;
    emitted = 1'b1;
    sx = dir_x_neg ? -1 : 1;
    sy = dir_y_neg ? -1 : 1;
    fin = ((steep ? pos_y : pos_x) == major_stop);
    nx = pos_x;
    ny = pos_y;
    if (steep) nx = OUT_W'(pos_x + sx);
    else ny = OUT_W'(pos_y + sy);
    px.main_x     = pos_x;
    px.main_y     = pos_y;
    px.main_cover = als_pkg::COVER_FULL ^ alpha;
    if (!flat) begin
      px.side_x     = nx;
      px.side_y     = ny;
      px.side_cover = alpha;
      px.side_valid = 1'b1;
    end
    px.last = fin;
    if (fin) begin
      drawing = 1'b0;
      return;
    end
    if (!flat) begin
      if (!err_acc[ERR_W-1]) begin
        alpha   = '0;
        err_acc = err_acc + ERR_W'(slope) - als_pkg::ONE_FIX;
        if (steep) pos_x = OUT_W'(pos_x + sx);
        else pos_y = OUT_W'(pos_y + sy);
      end else begin
        alpha   = err_acc[15:8];
        err_acc = err_acc + ERR_W'(slope);
      end
    end
    if (steep) pos_y = OUT_W'(pos_y + sy);
    else pos_x = OUT_W'(pos_x + sx);
  endtask

  task automatic report_fault(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [OUT_W-1:0] got,
                             input logic [OUT_W-1:0] want);
    if (got !== want)
      report_fault($sformatf("pair %0d: %s is %h, expected %h", pairs_checked, name,
                             got, want));
  endtask

  task automatic compare_pair(input pixel_pair_t want);
    check_field("main_x", out_mon.main_x, want.main_x);
    check_field("main_y", out_mon.main_y, want.main_y);
    check_field("main_cover", OUT_W'(out_mon.main_cover), OUT_W'(want.main_cover));
    check_field("side_x", out_mon.side_x, want.side_x);
    check_field("side_y", out_mon.side_y, want.side_y);
    check_field("side_cover", OUT_W'(out_mon.side_cover), OUT_W'(want.side_cover));
    check_field("side_valid", OUT_W'(out_mon.side_valid), OUT_W'(want.side_valid));
    check_field("last", OUT_W'(out_mon.last), OUT_W'(want.last));
  endtask

  always @(posedge clk) begin
    bit          emitted;
    pixel_pair_t want;
    if (!rst_n) begin
      clear_line_state();
      expected_pairs.delete();
      mismatches     = 0;
      pairs_checked  = 0;
      lines_finished = 0;
    end else begin
      // A pair leaving now was predicted at an earlier edge, so it is matched first.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_pairs.size() == 0) begin
          report_fault("pixel pair arrived with nothing expected");
        end else begin
          want = expected_pairs.pop_front();
          compare_pair(want);
          pairs_checked++;
          if (want.last) lines_finished++;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.op == als_pkg::OP_LOAD) begin
          latch_line(int'(in_mon.start_x) & COORD_MASK, int'(in_mon.start_y) & COORD_MASK,
                     int'(in_mon.end_x) & COORD_MASK, int'(in_mon.end_y) & COORD_MASK);
        end else begin
          predict_pair(emitted, want);
          if (emitted) expected_pairs.push_back(want);
        end
      end
    end
    outstanding <= expected_pairs.size();
  end

endmodule

>>> tb/testbench.sv
// Top of the line stepper bench. It generates clock and reset, sends load and
// step items, plays the receiver of the pixel pairs and gives the verdict. All
// prediction and comparison live in the checker instantiated beside the block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Counted items to send in the random part, spread over several phases.
  localparam int TARGET_ITEMS  = 950;
  localparam int PHASES        = 6;
  // A non-axis-aligned load keeps the block busy while the slope is divided, so this
  // covers any work still running after the last expected pair has come out.
  localparam int SETTLE_CYCLES = 40;
  // Length of the one long receiver hold-off.
  localparam int HOLD_CYCLES   = 300;
  localparam int IN_W          = als_pkg::IN_W;
  localparam int COORD_MAX     = (1 << IN_W) - 1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  als_in_if  in_line();
  als_out_if out_pix();

  int mismatches, outstanding, pairs_checked, lines_finished;

  // Idle switches for both sides and the request for the long hold-off. These
  // are written by the stimulus process and read by the receiver process.
  bit src_idle, snk_idle, hold_req;
  int items_sent, loads_sent, steps_sent;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  antialiased_line_stepper u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_line (in_line),
    .out_pix (out_pix)
  );

  line_pixel_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_line),
    .out_mon        (out_pix),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .pairs_checked  (pairs_checked),
    .lines_finished (lines_finished)
  );

  // Number of idle cycles before the next item on one side, when that side idles.
  function automatic int draw_wait(input bit enabled);
    return enabled ? int'($urandom_range(0, 13)) : 0;
  endfunction

  // Coordinates cluster at both borders a good part of the time, so that the
  // neighbor pixel lands at -1 and at 4096 often enough.
  function automatic int pick_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 8);
      1:       return COORD_MAX - $urandom_range(0, 8);
      default: return $urandom_range(0, COORD_MAX);
    endcase
  endfunction

  // Offers one item and returns at the edge where it is accepted. When no gap is
  // drawn, valid simply stays high and only the payload changes, so valid never
  // gets two assignments in one time step.
  task automatic send_item(input als_pkg::op_t op, input int sx, input int sy, input int ex,
                           input int ey, input bit counted);
    int gap;
    gap = draw_wait(src_idle);
    if (gap > 0) begin
      in_line.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_line.valid   <= 1'b1;
    in_line.op      <= op;
    in_line.start_x <= IN_W'(sx);
    in_line.start_y <= IN_W'(sy);
    in_line.end_x   <= IN_W'(ex);
    in_line.end_y   <= IN_W'(ey);
    @(posedge clk);
    while (!in_line.ready) @(posedge clk);
    if (counted) items_sent++;
    if (op == als_pkg::OP_LOAD) loads_sent++;
    else steps_sent++;
  endtask

  task automatic load_line(input int sx, input int sy, input int ex, input int ey);
    send_item(als_pkg::OP_LOAD, sx, sy, ex, ey, 1'b1);
  endtask

  // Step items carry random end point fields, which the block must ignore.
  task automatic advance(input int n, input bit counted);
    repeat (n)
      send_item(als_pkg::OP_STEP, $urandom_range(0, COORD_MAX),
                $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                $urandom_range(0, COORD_MAX), counted);
  endtask

  // Loads a line whose major length is at most max_major and steps it to its
  // end point. Now and then one more step runs past the end and is dropped.
  task automatic draw_random_line(input int max_major);
    int maj, mnr, x1, y1, x2, y2, dx, dy;
    bit tall;
    maj = $urandom_range(0, max_major);
    case ($urandom_range(0, 5))
      0:       mnr = 0;
      1:       mnr = maj;
      default: mnr = $urandom_range(0, maj);
    endcase
    tall = 1'($urandom_range(0, 1));
    dx = tall ? mnr : maj;
    dy = tall ? maj : mnr;
    x1 = pick_coord();
    y1 = pick_coord();
    x2 = $urandom_range(0, 1) ? x1 + dx : x1 - dx;
    y2 = $urandom_range(0, 1) ? y1 + dy : y1 - dy;
    // Mirror an end point that falls off the grid back to the other side.
    if (x2 < 0 || x2 > COORD_MAX) x2 = 2 * x1 - x2;
    if (y2 < 0 || y2 > COORD_MAX) y2 = 2 * y1 - y2;
    load_line(x1, y1, x2, y2);
    advance(maj + 1, 1'b1);
    if ($urandom_range(0, 7) == 0) advance(1, 1'b0);
  endtask

  // Stops offering items and waits until every predicted pair has come out,
  // then lets the block settle. The first edge makes sure the count already
  // includes the item accepted at the current edge.
  task automatic wait_for_drain();
    in_line.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver. For every pair it draws a stall, then holds ready high until a
  // pair is taken. Once during the run it holds ready low for a long stretch,
  // while the sender keeps offering steps, so that the block backs up.
  initial begin : receiver
    int stall;
    out_pix.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = draw_wait(snk_idle);
      end
      if (stall > 0) begin
        out_pix.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pix.ready <= 1'b1;
      @(posedge clk);
      while (!out_pix.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int phase;
    int quota;
    in_line.valid   <= 1'b0;
    in_line.op      <= als_pkg::OP_LOAD;
    in_line.start_x <= '0;
    in_line.start_y <= '0;
    in_line.end_x   <= '0;
    in_line.end_y   <= '0;
    src_idle = 1'b0;
    snk_idle = 1'b0;
    hold_req = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, sent back to back.
    // A step with no line loaded is dropped.
    advance(1, 1'b0);
    // Single points at both corners of the grid; the extra step falls past the end.
    load_line(0, 0, 0, 0);
    advance(2, 1'b1);
    load_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    advance(1, 1'b1);
    // Horizontal line running leftward: full coverage, no neighbor.
    load_line(COORD_MAX, 7, COORD_MAX - 2, 7);
    advance(3, 1'b1);
    // Shallow line falling toward y = 0: the last neighbor sits at y = -1.
    load_line(0, 2, 4, 0);
    advance(5, 1'b1);
    // Steep line at the right border: the neighbor reaches x = 4096.
    load_line(COORD_MAX - 1, COORD_MAX - 2, COORD_MAX, COORD_MAX);
    advance(3, 1'b1);
    // Diagonal with slope exactly one, cut short by the next load.
    load_line(0, 0, 3, 3);
    advance(2, 1'b1);
    // Steep line with x running backward, stepped to its end.
    load_line(5, 1, 4, 4);
    advance(4, 1'b1);

    // Random part. Each phase has its own idle pattern. The long receiver
    // hold-off comes at the start of the third phase with the sender at full
    // rate, and the sender drains everything before the fifth phase.
    quota = items_sent;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          src_idle = 1'b1;
          snk_idle = 1'b1;
        end
        1: begin
          src_idle = 1'b0;
          snk_idle = 1'b0;
        end
        2: begin
          src_idle = 1'b0;
          snk_idle = 1'b1;
          hold_req = 1'b1;
        end
        3: begin
          src_idle = 1'b1;
          snk_idle = 1'b0;
        end
        4: begin
          wait_for_drain();
          src_idle = 1'b1;
          snk_idle = 1'b1;
        end
        default: begin
          src_idle = 1'($urandom_range(0, 1));
          snk_idle = 1'($urandom_range(0, 1));
        end
      endcase
      quota += TARGET_ITEMS / PHASES;
      while (items_sent < quota) begin
        case ($urandom_range(0, 15))
          0, 1: begin
            // Any two points on the grid, abandoned after a few steps by the
            // next load; this exercises the divider over its whole range.
            load_line($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                      $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
            advance($urandom_range(0, 8), 1'b1);
          end
          2:       advance(1, 1'b0);
          3:       draw_random_line(60);
          default: draw_random_line(12);
        endcase
      end
    end

    wait_for_drain();
    $display("Run covered %0d loads and %0d steps; %0d pixel pairs checked,",
             loads_sent, steps_sent, pairs_checked);
    $display("%0d lines drawn to their end, one %0d-cycle receiver hold-off and a full drain.",
             lines_finished, HOLD_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
